[src/vtgd_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the vector tile geometry decoder.
// No dependencies.
package vtgd_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned IdW     = 3;
  localparam int unsigned PairsW  = WordW - IdW;
  localparam int unsigned OutW    = 32;
  localparam int unsigned CountW  = 24;
  localparam int unsigned AreaW   = 64;

  // Command ids
  localparam logic [IdW-1:0] CmdMove  = 3'd1;
  localparam logic [IdW-1:0] CmdLine  = 3'd2;
  localparam logic [IdW-1:0] CmdClose = 3'd7;

  localparam logic [CountW-1:0] RingMinPts = 24'd3;
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  // Result kinds
  localparam logic KindPoint = 1'b0;
  localparam logic KindRing  = 1'b1;

  typedef struct packed {
    logic [WordW-1:0] geometry_word;
    logic             feature_start;
  } in_beat_t;

  typedef struct packed {
    logic                    kind;
    logic signed [OutW-1:0]  point_x;
    logic signed [OutW-1:0]  point_y;
    logic                    starts_ring;
    logic [CountW-1:0]       ring_points;
    logic                    exterior;
  } out_beat_t;

endpackage

[src/vtgd_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for geometry words and decoded results.
// Depends on vtgd_pkg.
interface vtgd_in_if import vtgd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vtgd_out_if import vtgd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/vector_tile_geometry_decoder.sv]
`timescale 1ns / 1ps
// Vector tile geometry decoder: one geometry word per cycle in while not stalled, points and ring summaries out.
// A result beat passes the s1, s2, s3 and out registers after the word that causes it is accepted.
// Throughput: one word per cycle; stalls only when all four result stages are full and out_o.ready is low.
// Reset (async, active low): decode state, area sum and all stage valids cleared.
// Depends on vtgd_pkg and vtgd_if.
module vector_tile_geometry_decoder import vtgd_pkg::*; #(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  vtgd_in_if.sink    in_i,
  vtgd_out_if.source out_o
);

  localparam int unsigned CW = COORD_WIDTH;

  // decode phase codes
  localparam logic [1:0] PhCmd = 2'd0;
  localparam logic [1:0] PhDx  = 2'd1;
  localparam logic [1:0] PhDy  = 2'd2;

  // ---------------------------------------------------------------------------
  // Decode state (updated at each accepted beat)
  // ---------------------------------------------------------------------------
  logic [1:0]           phase_q, phase_d;
  logic                 move_q, move_d;
  logic [PairsW-1:0]    pairs_q, pairs_d;
  logic signed [CW-1:0] pend_q, pend_d;
  logic signed [CW-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [CW-1:0] first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CountW-1:0]    ring_q, ring_d;
  logic                 halt_q, halt_d;

  // state as seen by this beat: a feature start puts it back to reset values
  logic [1:0]           phase_c;
  logic                 move_c;
  logic [PairsW-1:0]    pairs_c;
  logic signed [CW-1:0] pend_c, cur_x_c, cur_y_c, first_x_c, first_y_c;
  logic [CountW-1:0]    ring_c;
  logic                 halt_c;

  logic [WordW-1:0]     word;
  logic [IdW-1:0]       cmd_id;
  logic [PairsW-1:0]    cmd_cnt;
  logic [WordW-1:0]     dz;
  logic signed [CW-1:0] nx, ny;
  logic                 start_ring;

  // job handed to the result pipeline
  logic                 job_v;
  logic                 job_kind;
  logic                 job_clear;
  logic                 job_starts;
  logic [CountW-1:0]    job_pts;
  logic signed [CW-1:0] job_ax, job_ay, job_bx, job_by;
  logic signed [CW-1:0] job_px, job_py;

  logic accept;

  // ---------------------------------------------------------------------------
  // Result pipeline: s1 operands, s2 products, s3 edge term, out register
  // ---------------------------------------------------------------------------
  logic                 v1_q, v2_q, v3_q, vo_q;
  logic                 adv1, adv2, adv3, advo;

  logic                 kind1_q, clear1_q, starts1_q;
  logic [CountW-1:0]    pts1_q;
  logic signed [CW-1:0] px1_q, py1_q, ax1_q, ay1_q, bx1_q, by1_q;

  logic                 kind2_q, clear2_q, starts2_q;
  logic [CountW-1:0]    pts2_q;
  logic signed [CW-1:0] px2_q, py2_q;
  logic signed [2*CW-1:0] p1_q, p2_q;

  logic                 kind3_q, clear3_q, starts3_q;
  logic [CountW-1:0]    pts3_q;
  logic signed [CW-1:0] px3_q, py3_q;
  logic signed [AreaW-1:0] term3_q;

  logic signed [AreaW-1:0] area_q, area_d;
  logic signed [AreaW-1:0] area_sum;
  out_beat_t            out_q, out_d;

  // stage k loads when it is empty or its content moves on
  assign advo = !vo_q || out_o.ready;
  assign adv3 = !v3_q || advo;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;

  assign in_i.ready = adv1;
  assign accept     = in_i.valid && adv1;

  assign word    = in_i.data.geometry_word;
  assign cmd_id  = word[IdW-1:0];
  assign cmd_cnt = word[WordW-1:IdW];
  // zigzag: (v >> 1) ^ -(v & 1)
  assign dz      = (word >> 1) ^ {WordW{word[0]}};

  always_comb begin
    if (in_i.data.feature_start) begin
      phase_c   = PhCmd;
      move_c    = 1'b0;
      pairs_c   = '0;
      pend_c    = '0;
      cur_x_c   = '0;
      cur_y_c   = '0;
      first_x_c = '0;
      first_y_c = '0;
      ring_c    = '0;
      halt_c    = 1'b0;
    end else begin
      phase_c   = phase_q;
      move_c    = move_q;
      pairs_c   = pairs_q;
      pend_c    = pend_q;
      cur_x_c   = cur_x_q;
      cur_y_c   = cur_y_q;
      first_x_c = first_x_q;
      first_y_c = first_y_q;
      ring_c    = ring_q;
      halt_c    = halt_q;
    end
  end

  // coordinates wrap at CW bits
  assign nx         = cur_x_c + pend_c;
  assign ny         = cur_y_c + signed'(dz[CW-1:0]);
  assign start_ring = move_c || (ring_c == '0);

  always_comb begin
    phase_d   = phase_c;
    move_d    = move_c;
    pairs_d   = pairs_c;
    pend_d    = pend_c;
    cur_x_d   = cur_x_c;
    cur_y_d   = cur_y_c;
    first_x_d = first_x_c;
    first_y_d = first_y_c;
    ring_d    = ring_c;
    halt_d    = halt_c;

    job_v      = 1'b0;
    job_kind   = KindPoint;
    job_clear  = 1'b0;
    job_starts = 1'b0;
    job_pts    = '0;
    job_ax     = cur_x_c;
    job_ay     = cur_y_c;
    job_bx     = nx;
    job_by     = ny;
    job_px     = nx;
    job_py     = ny;

    if (!halt_c) begin
      case (phase_c)
        PhCmd: begin
          if (cmd_id == CmdMove || cmd_id == CmdLine) begin
            move_d  = (cmd_id == CmdMove);
            pairs_d = cmd_cnt;
            if (cmd_cnt != '0) phase_d = PhDx;
          end else if (cmd_id == CmdClose) begin
            // ring summary closes back to the first point
            if (ring_c >= RingMinPts) begin
              job_v    = 1'b1;
              job_kind = KindRing;
              job_pts  = ring_c;
              job_bx   = first_x_c;
              job_by   = first_y_c;
              job_px   = '0;
              job_py   = '0;
            end
            ring_d = '0;
          end else begin
            halt_d = 1'b1;
          end
        end
        PhDx: begin
          pend_d  = signed'(dz[CW-1:0]);
          phase_d = PhDy;
        end
        default: begin
          // dy word: move cursor and emit the point
          if (start_ring) begin
            first_x_d = nx;
            first_y_d = ny;
            ring_d    = {{(CountW-1){1'b0}}, 1'b1};
          end else if (ring_c != CountMax) begin
            ring_d = ring_c + 1'b1;
          end
          cur_x_d    = nx;
          cur_y_d    = ny;
          pairs_d    = pairs_c - 1'b1;
          phase_d    = (pairs_d == '0) ? PhCmd : PhDx;
          job_v      = 1'b1;
          job_clear  = start_ring;
          job_starts = move_c;
        end
      endcase
    end
  end

  // area update and close-time sum
  assign area_sum = area_q + term3_q;

  always_comb begin
    area_d = area_q;
    if (v3_q && kind3_q == KindPoint) begin
      area_d = clear3_q ? '0 : area_sum;
    end
    out_d.kind        = kind3_q;
    out_d.point_x     = OutW'(px3_q);
    out_d.point_y     = OutW'(py3_q);
    out_d.starts_ring = starts3_q;
    out_d.ring_points = pts3_q;
    out_d.exterior    = (kind3_q == KindRing) && !area_sum[AreaW-1] && (area_sum != '0);
  end

  // control and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhCmd;
      move_q    <= 1'b0;
      pairs_q   <= '0;
      pend_q    <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      first_x_q <= '0;
      first_y_q <= '0;
      ring_q    <= '0;
      halt_q    <= 1'b0;
      area_q    <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      vo_q      <= 1'b0;
    end else begin
      if (accept) begin
        phase_q   <= phase_d;
        move_q    <= move_d;
        pairs_q   <= pairs_d;
        pend_q    <= pend_d;
        cur_x_q   <= cur_x_d;
        cur_y_q   <= cur_y_d;
        first_x_q <= first_x_d;
        first_y_q <= first_y_d;
        ring_q    <= ring_d;
        halt_q    <= halt_d;
      end
      if (advo) area_q <= area_d;
      if (adv1) v1_q <= accept && job_v;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
      if (advo) vo_q <= v3_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv1) begin
      kind1_q   <= job_kind;
      clear1_q  <= job_clear;
      starts1_q <= job_starts;
      pts1_q    <= job_pts;
      px1_q     <= job_px;
      py1_q     <= job_py;
      ax1_q     <= job_ax;
      ay1_q     <= job_ay;
      bx1_q     <= job_bx;
      by1_q     <= job_by;
    end
    if (adv2) begin
      kind2_q   <= kind1_q;
      clear2_q  <= clear1_q;
      starts2_q <= starts1_q;
      pts2_q    <= pts1_q;
      px2_q     <= px1_q;
      py2_q     <= py1_q;
      p1_q      <= ax1_q * by1_q;
      p2_q      <= bx1_q * ay1_q;
    end
    if (adv3) begin
      kind3_q   <= kind2_q;
      clear3_q  <= clear2_q;
      starts3_q <= starts2_q;
      pts3_q    <= pts2_q;
      px3_q     <= px2_q;
      py3_q     <= py2_q;
      term3_q   <= AreaW'(p1_q) - AreaW'(p2_q);
    end
    if (advo) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = vo_q;
  assign out_o.data  = out_q;

endmodule
